@@ rtl/core/cht_pkg.sv @@
// shared types and constants for the cuckoo hash table
package cht_pkg;
  localparam int TABLE_DEPTH = 1024;
  localparam int SLOT_W = $clog2(TABLE_DEPTH);
  localparam int KEY_W = 31;
  localparam int VAL_W = 32;
  localparam int MULT_W = 31;
  localparam int KICK_W = 16;
  localparam int PROD_W = KEY_W + MULT_W;
  localparam int ADDR_W = 3;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED = 3'd1;
  localparam logic [2:0] ST_FOUND = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_DELETED = 3'd4;
  localparam logic [2:0] ST_FULL = 3'd5;

  localparam logic [ADDR_W-1:0] REG_MULT = 3'd0;
  localparam logic [ADDR_W-1:0] REG_KICKS = 3'd4;

  localparam logic [31:0] MULT_RESET = 32'd1000003;
  localparam logic [31:0] KICKS_RESET = 32'd2048;

  typedef struct packed {
    logic [1:0] func;
    logic [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic signed [VAL_W-1:0] found_value;
    logic [KEY_W-1:0] dropped_key;
    logic signed [VAL_W-1:0] dropped_value;
  } rsp_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture request, start hash of request key
    logic hash_hold; // start hash of held key
    logic rd1;       // read table one at held slot one
    logic rd2;       // read table two at held slot two
    logic wr1;       // write held entry into table one
    logic wr2;       // write held entry into table two
    logic upd1;      // update value in table one
    logic upd2;      // update value in table two
    logic del1;
    logic del2;
    logic swap1;     // take old table one entry as held
    logic swap2;
    logic kick_clr;
    logic kick_inc;
    logic rsp_load;
    logic [2:0] rsp_status;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [1:0] func;
    logic hit1;
    logic hit2;
    logic was1;
    logic was2;
    logic kicks_done;
    logic clr_busy;  // valid bit clearing pass still running
  } sts_t;
endpackage

@@ rtl/core/cht_datapath.sv @@
// hashing, table storage and held entry registers
module cht_datapath import cht_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  input  logic [MULT_W-1:0] mult,
  input  logic [KICK_W-1:0] max_kicks,
  output sts_t sts,
  output rsp_t rsp
);
  logic [KEY_W-1:0] hk;
  logic signed [VAL_W-1:0] hv;
  logic [1:0] func;
  logic [PROD_W-1:0] prod;
  logic [KEY_W-1:0] mkey;
  logic [SLOT_W-1:0] s1, s2;
  logic v1 [TABLE_DEPTH];
  logic v2 [TABLE_DEPTH];
  logic [KEY_W-1:0] k1 [TABLE_DEPTH];
  logic [KEY_W-1:0] k2 [TABLE_DEPTH];
  logic [VAL_W-1:0] d1 [TABLE_DEPTH];
  logic [VAL_W-1:0] d2 [TABLE_DEPTH];
  logic [KEY_W-1:0] rk1, rk2;
  logic [VAL_W-1:0] rd1, rd2;
  logic rv1, rv2;
  logic [KICK_W-1:0] kicks;
  logic clr_busy;
  logic [SLOT_W-1:0] clr_addr;

  assign mkey = cmd.load ? req.key : hk;

  // registered product, slots are bit fields of it
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.hash_hold) begin
      prod <= PROD_W'(mkey) * PROD_W'(mult);
    end
  end
  assign s1 = prod[SLOT_W-1:0];
  assign s2 = prod[2*SLOT_W-1:SLOT_W];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hk <= req.key;
      hv <= req.value;
      func <= req.func;
    end else if (cmd.swap1) begin
      hk <= rk1;
      hv <= rd1;
    end else if (cmd.swap2) begin
      hk <= rk2;
      hv <= rd2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd1) begin
      rk1 <= k1[s1];
      rd1 <= d1[s1];
    end
    if (cmd.wr1) begin
      k1[s1] <= hk;
      d1[s1] <= hv;
    end else if (cmd.upd1) begin
      d1[s1] <= hv;
    end
    if (cmd.rd2) begin
      rk2 <= k2[s2];
      rd2 <= d2[s2];
    end
    if (cmd.wr2) begin
      k2[s2] <= hk;
      d2[s2] <= hv;
    end else if (cmd.upd2) begin
      d2[s2] <= hv;
    end
  end

  // one entry of each valid memory cleared per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + SLOT_W'(1);
      if (clr_addr == SLOT_W'(TABLE_DEPTH - 1)) clr_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      v1[clr_addr] <= 1'b0;
      v2[clr_addr] <= 1'b0;
    end else begin
      if (cmd.rd1) rv1 <= v1[s1];
      if (cmd.rd2) rv2 <= v2[s2];
      if (cmd.wr1) v1[s1] <= 1'b1;
      else if (cmd.del1) v1[s1] <= 1'b0;
      if (cmd.wr2) v2[s2] <= 1'b1;
      else if (cmd.del2) v2[s2] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.kick_clr) kicks <= '0;
    else if (cmd.kick_inc) kicks <= kicks + KICK_W'(1);
  end

  assign sts.func = func;
  assign sts.hit1 = rv1 && (rk1 == hk);
  assign sts.hit2 = rv2 && (rk2 == hk);
  assign sts.was1 = rv1;
  assign sts.was2 = rv2;
  // compare against count after this kick
  assign sts.kicks_done = (17'(kicks) + 17'd1) >= 17'(max_kicks);
  assign sts.clr_busy = clr_busy;

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      rsp.status <= cmd.rsp_status;
      rsp.found_value <= '0;
      rsp.dropped_key <= '0;
      rsp.dropped_value <= '0;
      if (cmd.rsp_status == ST_FOUND) rsp.found_value <= sts.hit1 ? rd1 : rd2;
      if (cmd.rsp_status == ST_FULL) begin
        rsp.dropped_key <= cmd.swap1 ? rk1 : rk2;
        rsp.dropped_value <= cmd.swap1 ? rd1 : rd2;
      end
    end
  end
endmodule

@@ rtl/core/cht_ctrl.sv @@
// sequencer for lookup, update, delete and kick chain
module cht_ctrl import cht_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [10:0] {
    S_CLR   = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_READ  = 11'b00000000100,
    S_LOOK  = 11'b00000001000,
    S_HASH1 = 11'b00000010000,
    S_PUT1  = 11'b00000100000,
    S_CHK1  = 11'b00001000000,
    S_HASH2 = 11'b00010000000,
    S_PUT2  = 11'b00100000000,
    S_CHK2  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else state <= state_next;
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_CLR: begin
        if (!sts.clr_busy) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd1 = 1'b1;
        cmd.rd2 = 1'b1;
        state_next = S_LOOK;
      end
      S_LOOK: begin
        cmd.rsp_load = 1'b1;
        state_next = S_OUT;
        case (sts.func)
          OP_FIND: cmd.rsp_status = (sts.hit1 || sts.hit2) ? ST_FOUND : ST_NOT_FOUND;
          OP_DELETE: begin
            cmd.del1 = sts.hit1;
            cmd.del2 = !sts.hit1 && sts.hit2;
            cmd.rsp_status = (sts.hit1 || sts.hit2) ? ST_DELETED : ST_NOT_FOUND;
          end
          OP_INSERT: begin
            if (sts.hit1) begin
              cmd.upd1 = 1'b1;
              cmd.rsp_status = ST_UPDATED;
            end else if (sts.hit2) begin
              cmd.upd2 = 1'b1;
              cmd.rsp_status = ST_UPDATED;
            end else begin
              cmd.rsp_load = 1'b0;
              cmd.wr1 = 1'b1;
              cmd.kick_clr = 1'b1;
              state_next = S_CHK1;
            end
          end
          default: cmd.rsp_status = ST_NOT_FOUND;
        endcase
      end
      S_HASH1: begin
        cmd.hash_hold = 1'b1;
        state_next = S_PUT1;
      end
      S_PUT1: begin
        cmd.rd1 = 1'b1;
        cmd.wr1 = 1'b1;
        state_next = S_CHK1;
      end
      S_CHK1: begin
        // old table one entry in rk1/rd1 (read at S_READ or S_PUT1)
        if (!sts.was1) begin
          cmd.rsp_load = 1'b1;
          cmd.rsp_status = ST_INSERTED;
          state_next = S_OUT;
        end else if (sts.kicks_done) begin
          cmd.rsp_load = 1'b1;
          cmd.rsp_status = ST_FULL;
          cmd.swap1 = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.swap1 = 1'b1;
          cmd.kick_inc = 1'b1;
          state_next = S_HASH2;
        end
      end
      S_HASH2: begin
        cmd.hash_hold = 1'b1;
        state_next = S_PUT2;
      end
      S_PUT2: begin
        cmd.rd2 = 1'b1;
        cmd.wr2 = 1'b1;
        state_next = S_CHK2;
      end
      S_CHK2: begin
        // table two result now registered
        if (!sts.was2) begin
          cmd.rsp_load = 1'b1;
          cmd.rsp_status = ST_INSERTED;
          state_next = S_OUT;
        end else if (sts.kicks_done) begin
          cmd.rsp_load = 1'b1;
          cmd.rsp_status = ST_FULL;
          state_next = S_OUT;
        end else begin
          cmd.swap2 = 1'b1;
          cmd.kick_inc = 1'b1;
          state_next = S_HASH1;
        end
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

@@ rtl/core/cuckoo_hash_table.sv @@
// top level of the two-table cuckoo hash map
// channels: req beat (func, key, value) on req_valid/req_ready, one rsp beat
// per request on rsp_valid/rsp_ready; config via apb-style port
// registers: 0x0 hash_multiplier (31 bits), 0x4 max_kicks (16 bits)
// each request: hash product is registered, then both tables are read
// find, delete and update step through accept, read, lookup and
// response states; rsp_valid rises on entry to the response state
// an insert that finds slot one empty adds a check state before response
// each displacement along the kick chain adds hash, read and write, and
// check states, since the multiplier product and the table reads are
// registered
// an insert makes up to max_kicks kicks
// one request is in flight at a time; req_ready is low until the
// response beat has been taken
// after reset a clearing pass zeroes the valid bits one slot per cycle,
// so req_ready is low until the pass ends; config goes to reset values
// while the receiver stalls the response holds and no request is taken
module cuckoo_hash_table import cht_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [MULT_W-1:0] mult;
  logic [KICK_W-1:0] max_kicks;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  // config registers, written in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      mult <= MULT_RESET[MULT_W-1:0];
      max_kicks <= KICKS_RESET[KICK_W-1:0];
    end else if (psel && penable && pwrite) begin
      if (paddr == REG_MULT) mult <= pwdata[MULT_W-1:0];
      if (paddr == REG_KICKS) max_kicks <= pwdata[KICK_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_MULT) prdata = {1'b0, mult};
    else if (paddr == REG_KICKS) prdata = {16'd0, max_kicks};
  end

  cht_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req_valid), .in_ready(req_ready),
    .out_valid(rsp_valid), .out_ready(rsp_ready),
    .sts(sts), .cmd(cmd)
  );

  cht_datapath u_dp (
    .clk(clk), .rst(rst), .req(req), .cmd(cmd),
    .mult(mult), .max_kicks(max_kicks), .sts(sts), .rsp(rsp)
  );
endmodule

@@ rtl/core/cht_checker.sv @@
// port-level checks for the cuckoo hash table
module cht_checker import cht_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid)) else $error("ready while response pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp)) else $error("rsp changed");
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= ST_FULL) else $error("bad status");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready) else $error("double accept");
endmodule

bind cuckoo_hash_table cht_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
  .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
